### rtl/sdspi_pkg.sv
package sdspi_pkg;

    localparam int BLOCK_BYTES         = 512;
    localparam int RESPONSE_POLL_LIMIT = 4096;
    localparam int TOKEN_POLL_LIMIT    = 4095;
    localparam int INIT_POLL_LIMIT     = 65535;
    localparam int BLOCK_SHIFT         = $clog2(BLOCK_BYTES);

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_INIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CLOCKS, PH_CMD, PH_RESP, PH_DESEL,
        PH_ANSWER, PH_TOKEN, PH_DATA, PH_CRC
    } t_phase;

    typedef enum logic [2:0] {
        NX_PROCEED, NX_RESEND, NX_FAIL, NX_SDINIT, NX_OCR, NX_CMD1, NX_READ_OK
    } t_next;

    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_INIT_FAIL = 2'd1;
    localparam logic [1:0] RC_READ_FAIL = 2'd2;

    localparam logic [1:0] REG_RETRY = 2'd0;
    localparam logic [1:0] REG_HCE   = 2'd1;
    localparam logic [1:0] REG_MASK  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  rx_byte;
        logic [31:0] sector;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       card_select;
        logic [7:0] read_data;
        logic       read_data_valid;
        logic       done_res;
        logic [1:0] result_code;
    } t_out;

    // CRC7 over one byte, polynomial x^7+x^3+1
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
        logic [6:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[6] ^ b[i];
            c  = {c[5:0], 1'b0};
            if (fb) c = c ^ 7'h09;
        end
        return c;
    endfunction

    function automatic logic [6:0] crc7_cmd(input logic [5:0] cmd, input logic [31:0] arg);
        logic [6:0] c;
        c = crc7_byte(7'd0, {2'b01, cmd});
        c = crc7_byte(c, arg[31:24]);
        c = crc7_byte(c, arg[23:16]);
        c = crc7_byte(c, arg[15:8]);
        c = crc7_byte(c, arg[7:0]);
        return c;
    endfunction

endpackage

### rtl/sd_spi_host_init_and_read.sv
// SD card SPI-mode host sequencer.
// Each accepted item yields one registered result item (output register or skid).
// Throughput: one item per cycle while o_stall is low; output register with a skid stage.
// The CRC7 of a command is computed when the command is set up.
// Reset (synchronous, active low): idle phase, all but output data at defaults.
module sd_spi_host_init_and_read (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sdspi_pkg::t_in      i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sdspi_pkg::t_out     o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sdspi_pkg::*;

    logic [3:0]  r_retry_limit;
    logic        r_hce;
    logic [31:0] r_mask;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_byte_index, n_byte_index;
    logic [15:0] r_poll, n_poll;
    logic [3:0]  r_retry, n_retry;
    logic [5:0]  r_cmd, n_cmd;
    logic [31:0] r_arg, n_arg;
    logic [6:0]  r_crc, n_crc;
    logic [7:0]  r_last, n_last;
    logic [31:0] r_ans, n_ans;
    logic        r_hc, n_hc;
    logic [15:0] r_loop, n_loop;
    t_next       r_after, n_after;

    t_out        res;
    logic        r_ov, r_sv;
    t_out        r_od, r_sd;
    logic        accept, out_take;

    assign pready  = 1'b1;
    assign o_stall = r_sv;
    assign accept  = i_valid && !r_sv;
    assign out_take = o_valid && !i_stall;
    assign o_valid = r_ov;
    assign o_data  = r_od;

    always_comb begin
        unique case (paddr[3:2])
            REG_RETRY: prdata = {28'd0, r_retry_limit};
            REG_HCE:   prdata = {31'd0, r_hce};
            REG_MASK:  prdata = r_mask;
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= 4'd3;
            r_hce         <= 1'b1;
            r_mask        <= 32'h00FF8000;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_RETRY: r_retry_limit <= pwdata[3:0];
                REG_HCE:   r_hce         <= pwdata[0];
                REG_MASK:  r_mask        <= pwdata;
                default: ;
            endcase
        end
    end

    // Command bytes are sent straight from the argument; CRC is stored per command.
    logic [7:0]  cmd_byte;
    logic [3:0]  lim;
    logic [3:0]  retry_inc;
    logic [31:0] ans_next;
    logic [15:0] loop_dec;
    logic [15:0] poll_inc;
    logic [9:0]  bi_inc;

    // events set a command via these locals
    logic        bc;     // begin command
    logic [5:0]  bcmd;
    logic [31:0] barg;
    logic        bfresh;
    logic        prc;    // run proceed on last response
    logic [7:0]  pr;
    logic        ds;
    t_next       dnx;
    logic        fin;
    logic [1:0]  fcode;
    logic        ans_start;
    logic        emitff;
    logic        emitcs;

    always_comb begin
        n_phase = r_phase; n_byte_index = r_byte_index; n_poll = r_poll;
        n_retry = r_retry; n_cmd = r_cmd; n_arg = r_arg; n_crc = r_crc;
        n_last = r_last; n_ans = r_ans; n_hc = r_hc; n_loop = r_loop;
        n_after = r_after;
        res = '0;
        cmd_byte = 8'd0;
        lim = (r_retry_limit == 4'd0) ? 4'd1 : r_retry_limit;
        retry_inc = r_retry + 4'd1;
        ans_next = {r_ans[23:0], i_data.rx_byte};
        loop_dec = r_loop - 16'd1;
        poll_inc = r_poll + 16'd1;
        bi_inc = r_byte_index + 10'd1;
        bc = 1'b0; bcmd = '0; barg = '0; bfresh = 1'b1; prc = 1'b0;
        pr = r_last; ds = 1'b0; dnx = NX_PROCEED; fin = 1'b0;
        fcode = RC_OK; ans_start = 1'b0; emitff = 1'b0; emitcs = 1'b0;

        if (accept) begin
            priority if (i_data.opcode == OP_INIT) begin
                n_hc = 1'b0; n_phase = PH_CLOCKS; n_byte_index = '0;
                res.tx_byte = 8'hFF; res.tx_valid = 1'b1;
            end else if (i_data.opcode == OP_READ) begin
                n_cmd = 6'd17;
                n_arg = r_hc ? i_data.sector : {i_data.sector[31-BLOCK_SHIFT:0],
                                               {BLOCK_SHIFT{1'b0}}};
                n_crc = crc7_cmd(6'd17, n_arg);
                n_byte_index = '0; n_retry = '0; n_phase = PH_CMD;
                res.tx_byte = 8'h51; res.tx_valid = 1'b1; res.card_select = 1'b1;
            end else if (i_data.opcode == OP_BYTE && r_phase != PH_IDLE) begin
                unique case (r_phase)
                    PH_CLOCKS: begin
                        n_byte_index = bi_inc;
                        if (bi_inc < 10'd10) emitff = 1'b1;
                        else begin bc = 1'b1; bcmd = 6'd0; barg = '0; end
                    end
                    PH_CMD: begin
                        n_byte_index = bi_inc;
                        if (bi_inc < 10'd6) begin
                            if (bi_inc < 10'd5)
                                cmd_byte = 8'(r_arg >> (6'd8 * (6'd4 - 6'(bi_inc))));
                            else cmd_byte = {r_crc, 1'b1};
                            res.tx_byte = cmd_byte; res.tx_valid = 1'b1;
                            res.card_select = 1'b1;
                        end else begin
                            n_phase = PH_RESP; n_poll = '0; emitff = 1'b1; emitcs = 1'b1;
                        end
                    end
                    PH_RESP: begin
                        n_poll = poll_inc;
                        if (i_data.rx_byte[7] && poll_inc < 16'(RESPONSE_POLL_LIMIT)) begin
                            emitff = 1'b1; emitcs = 1'b1;
                        end else begin
                            n_last = i_data.rx_byte;
                            if (r_cmd != 6'd8 && r_cmd != 6'd58 && r_cmd != 6'd17) begin
                                ds = 1'b1;
                                if (i_data.rx_byte[3]) begin
                                    n_retry = retry_inc;
                                    dnx = (retry_inc < lim) ? NX_RESEND : NX_PROCEED;
                                end else dnx = NX_PROCEED;
                            end else begin
                                prc = 1'b1; pr = i_data.rx_byte;
                            end
                        end
                    end
                    PH_DESEL: begin
                        unique case (r_after)
                            NX_PROCEED: prc = 1'b1;
                            NX_RESEND: begin
                                bc = 1'b1; bcmd = r_cmd; barg = r_arg; bfresh = 1'b0;
                            end
                            NX_SDINIT: begin
                                n_loop = 16'(INIT_POLL_LIMIT); bc = 1'b1; bcmd = 6'd55;
                            end
                            NX_OCR: begin bc = 1'b1; bcmd = 6'd58; end
                            NX_CMD1: begin
                                n_loop = 16'(INIT_POLL_LIMIT); bc = 1'b1; bcmd = 6'd1;
                                barg = 32'h40000000;
                            end
                            NX_READ_OK: begin fin = 1'b1; fcode = RC_OK; end
                            default: begin fin = 1'b1; fcode = RC_INIT_FAIL; end
                        endcase
                    end
                    PH_ANSWER: begin
                        n_ans = ans_next; n_byte_index = bi_inc;
                        if (bi_inc < 10'd4) begin emitff = 1'b1; emitcs = 1'b1; end
                        else if (r_cmd == 6'd8) begin
                            ds = 1'b1;
                            dnx = (ans_next[11:8] != 4'd1) ? NX_FAIL : NX_SDINIT;
                        end else if ((ans_next & r_mask) == 32'd0) begin
                            ds = 1'b1; dnx = NX_FAIL;
                        end else begin
                            if (r_hce && ans_next[30]) n_hc = 1'b1;
                            n_loop = 16'(INIT_POLL_LIMIT); bc = 1'b1; bcmd = 6'd1;
                            barg = 32'h40000000;
                        end
                    end
                    PH_TOKEN: begin
                        if (i_data.rx_byte == 8'hFE) begin
                            n_phase = PH_DATA; n_poll = '0; emitff = 1'b1; emitcs = 1'b1;
                        end else if (r_poll < 16'(TOKEN_POLL_LIMIT)) begin
                            n_poll = poll_inc; emitff = 1'b1; emitcs = 1'b1;
                        end else begin fin = 1'b1; fcode = RC_READ_FAIL; end
                    end
                    PH_DATA: begin
                        res.read_data = i_data.rx_byte; res.read_data_valid = 1'b1;
                        n_poll = poll_inc; emitff = 1'b1; emitcs = 1'b1;
                        if (poll_inc >= 16'(BLOCK_BYTES)) begin
                            n_phase = PH_CRC; n_byte_index = '0;
                        end
                    end
                    PH_CRC: begin
                        n_byte_index = bi_inc;
                        if (bi_inc < 10'd2) begin emitff = 1'b1; emitcs = 1'b1; end
                        else begin ds = 1'b1; dnx = NX_READ_OK; end
                    end
                    default: ;
                endcase

                if (prc) begin
                    unique case (r_cmd)
                        6'd0: begin
                            if (pr != 8'd1) begin fin = 1'b1; fcode = RC_INIT_FAIL; end
                            else if (r_hce) begin bc = 1'b1; bcmd = 6'd8; barg = 32'h1AA; end
                            else begin
                                n_loop = 16'(INIT_POLL_LIMIT); bc = 1'b1; bcmd = 6'd55;
                            end
                        end
                        6'd8: begin
                            if (pr > 8'd1) begin ds = 1'b1; dnx = NX_SDINIT; end
                            else ans_start = 1'b1;
                        end
                        6'd55: begin
                            if (pr > 8'd1) begin
                                n_loop = 16'(INIT_POLL_LIMIT); bc = 1'b1; bcmd = 6'd58;
                            end else begin bc = 1'b1; bcmd = 6'd41; barg = 32'h40000000; end
                        end
                        6'd41: begin
                            if (pr == 8'd1 && loop_dec != 16'd0) begin
                                n_loop = loop_dec; bc = 1'b1; bcmd = 6'd55;
                            end else begin
                                n_loop = 16'(INIT_POLL_LIMIT); bc = 1'b1; bcmd = 6'd58;
                            end
                        end
                        6'd58: begin
                            if (pr > 8'd1) begin
                                n_loop = loop_dec; ds = 1'b1;
                                dnx = (loop_dec != 16'd0) ? NX_OCR : NX_CMD1;
                            end else ans_start = 1'b1;
                        end
                        6'd1: begin
                            if (pr != 8'd0) begin
                                n_loop = loop_dec;
                                if (loop_dec != 16'd0) begin
                                    bc = 1'b1; bcmd = 6'd1; barg = 32'h40000000;
                                end else begin fin = 1'b1; fcode = RC_INIT_FAIL; end
                            end else begin
                                bc = 1'b1; bcmd = 6'd16; barg = 32'(BLOCK_BYTES);
                            end
                        end
                        6'd16: begin fin = 1'b1; fcode = (pr != 8'd0) ? RC_INIT_FAIL : RC_OK; end
                        6'd17: begin
                            if (pr != 8'd0) begin fin = 1'b1; fcode = RC_READ_FAIL; end
                            else begin
                                n_phase = PH_TOKEN; n_poll = '0; emitff = 1'b1; emitcs = 1'b1;
                            end
                        end
                        default: begin fin = 1'b1; fcode = RC_INIT_FAIL; end
                    endcase
                end

                if (ans_start) begin
                    n_phase = PH_ANSWER; n_byte_index = '0; n_ans = '0;
                    emitff = 1'b1; emitcs = 1'b1;
                end
                if (emitff) begin
                    res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.card_select = emitcs;
                end
                if (ds) begin
                    n_phase = PH_DESEL; n_after = dnx;
                    res.tx_byte = 8'hFF; res.tx_valid = 1'b1; res.card_select = 1'b0;
                end
                if (bc) begin
                    n_cmd = bcmd; n_arg = barg; n_crc = crc7_cmd(bcmd, barg);
                    n_byte_index = '0; n_phase = PH_CMD;
                    if (bfresh) n_retry = '0;
                    res.tx_byte = {2'b01, bcmd}; res.tx_valid = 1'b1;
                    res.card_select = 1'b1;
                end
                if (fin) begin
                    n_phase = PH_IDLE;
                    res.tx_byte = '0; res.tx_valid = 1'b0; res.card_select = 1'b0;
                    res.done_res = 1'b1; res.result_code = fcode;
                end
            end else begin
                res = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_byte_index <= '0; r_poll <= '0; r_retry <= '0;
            r_cmd <= '0; r_arg <= '0; r_crc <= '0; r_last <= 8'hFF; r_ans <= '0;
            r_hc <= 1'b0; r_loop <= '0; r_after <= NX_PROCEED;
        end else begin
            r_phase <= n_phase; r_byte_index <= n_byte_index; r_poll <= n_poll;
            r_retry <= n_retry; r_cmd <= n_cmd; r_arg <= n_arg; r_crc <= n_crc;
            r_last <= n_last; r_ans <= n_ans; r_hc <= n_hc; r_loop <= n_loop;
            r_after <= n_after;
        end
    end

    // output register plus skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            if (r_sv) begin
                if (out_take) begin r_ov <= 1'b1; r_sv <= 1'b0; end
            end else if (accept) begin
                if (!r_ov || out_take) r_ov <= 1'b1;
                else r_sv <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_take) r_od <= r_sd;
        end else if (accept) begin
            if (!r_ov || out_take) r_od <= res;
            else r_sd <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid holds item while output empty");
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_stall) |=> !r_sv) else $error("skid did not drain");
    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res.done_res) |=> r_phase == PH_IDLE) else $error("done without idle");
    a_cs_needs_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_data.card_select || o_data.tx_valid)) else $error("cs without tx");
`endif

endmodule

### tb/sd_spi_host_init_and_read_tb.sv
`timescale 1ns / 1ps

module sd_spi_host_init_and_read_tb;
    import sdspi_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 450;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
    localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
    localparam logic [5:0] CMD_APP_OP     = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;
    localparam logic [5:0] CMD_READ_OCR   = 6'd58;
    localparam logic [5:0] CMD_NO_FORCE   = 6'd63;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sd_spi_host_init_and_read DUT (.*);

    always #4 i_clk = ~i_clk;

    t_in  pending_items[$];
    t_out expected_results[$];
    bit   failed = 1'b0;
    int   cycles = 0;
    int   stim_count = 0;

    // ---------------- sequencer predictor ----------------
    logic [3:0]  cfg_retry = 4'd3;
    logic        cfg_hce = 1'b1;
    logic [31:0] cfg_mask = 32'h00FF8000;

    t_phase      ph = PH_IDLE;
    logic [15:0] bidx = '0;
    logic [15:0] polls = '0;
    logic [3:0]  retries = '0;
    logic [5:0]  cmd = '0;
    logic [31:0] arg = '0;
    logic [6:0]  crc = '0;
    logic [7:0]  last_r = 8'hFF;
    logic [31:0] ocr_sh = '0;
    logic        hc = 1'b0;
    logic [15:0] loops = '0;
    t_next       nxt = NX_PROCEED;
    t_out        pr;

    logic [5:0]  force_cmd = CMD_NO_FORCE;
    logic [7:0]  force_val = 8'h00;

    function automatic logic [6:0] crc_step(input logic [6:0] c_in, input logic [7:0] b);
        logic [6:0] c;
        logic       fb;
        c = c_in;
        for (int i = 7; i >= 0; i--) begin
            fb = c[6] ^ b[i];
            c = {c[5:0], 1'b0};
            if (fb) c = c ^ 7'h09;
        end
        return c;
    endfunction

    function automatic void put_byte(input logic [7:0] b, input logic cs);
        pr.tx_byte = b;
        pr.tx_valid = 1'b1;
        pr.card_select = cs;
    endfunction

    function automatic void end_op(input logic [1:0] code);
        ph = PH_IDLE;
        pr.tx_byte = '0;
        pr.tx_valid = 1'b0;
        pr.card_select = 1'b0;
        pr.done_res = 1'b1;
        pr.result_code = code;
    endfunction

    function automatic void cmd_byte();
        if (bidx == 0) put_byte({2'b01, cmd}, 1'b1);
        else if (bidx < 5) put_byte(8'(arg >> (8 * (4 - bidx))), 1'b1);
        else put_byte({crc, 1'b1}, 1'b1);
    endfunction

    function automatic void issue(input logic [5:0] c, input logic [31:0] a, input bit fresh);
        cmd = c;
        arg = a;
        crc = crc_step(7'd0, {2'b01, c});
        crc = crc_step(crc, a[31:24]);
        crc = crc_step(crc, a[23:16]);
        crc = crc_step(crc, a[15:8]);
        crc = crc_step(crc, a[7:0]);
        bidx = 0;
        if (fresh) retries = 0;
        ph = PH_CMD;
        cmd_byte();
    endfunction

    function automatic void drop_cs(input t_next n);
        ph = PH_DESEL;
        nxt = n;
        put_byte(8'hFF, 1'b0);
    endfunction

    function automatic void poll_start(input logic [5:0] c, input logic [31:0] a);
        loops = 16'(INIT_POLL_LIMIT);
        issue(c, a, 1'b1);
    endfunction

    function automatic void answer_start();
        ph = PH_ANSWER;
        bidx = 0;
        ocr_sh = 0;
        put_byte(8'hFF, 1'b1);
    endfunction

    function automatic void evaluate();
        case (cmd)
            CMD_GO_IDLE: begin
                if (last_r != 1) end_op(RC_INIT_FAIL);
                else if (cfg_hce) issue(CMD_IF_COND, 32'h1AA, 1'b1);
                else poll_start(CMD_APP, 0);
            end
            CMD_IF_COND: begin
                if (last_r > 1) drop_cs(NX_SDINIT);
                else answer_start();
            end
            CMD_APP: begin
                if (last_r > 1) poll_start(CMD_READ_OCR, 0);
                else issue(CMD_APP_OP, 32'h40000000, 1'b1);
            end
            CMD_APP_OP: begin
                if (last_r == 1) begin
                    loops--;
                    if (loops != 0) issue(CMD_APP, 0, 1'b1);
                    else poll_start(CMD_READ_OCR, 0);
                end else begin
                    poll_start(CMD_READ_OCR, 0);
                end
            end
            CMD_READ_OCR: begin
                if (last_r > 1) begin
                    loops--;
                    drop_cs(loops != 0 ? NX_OCR : NX_CMD1);
                end else begin
                    answer_start();
                end
            end
            CMD_SEND_OP: begin
                if (last_r != 0) begin
                    loops--;
                    if (loops != 0) issue(CMD_SEND_OP, 32'h40000000, 1'b1);
                    else end_op(RC_INIT_FAIL);
                end else begin
                    issue(CMD_BLOCKLEN, BLOCK_BYTES, 1'b1);
                end
            end
            CMD_BLOCKLEN: end_op(last_r != 0 ? RC_INIT_FAIL : RC_OK);
            CMD_READ_BLOCK: begin
                if (last_r != 0) begin
                    end_op(RC_READ_FAIL);
                end else begin
                    ph = PH_TOKEN;
                    polls = 0;
                    put_byte(8'hFF, 1'b1);
                end
            end
            default: end_op(RC_INIT_FAIL);
        endcase
    endfunction

    function automatic void got_resp(input logic [7:0] r);
        logic [3:0] lim;
        last_r = r;
        if (cmd != CMD_IF_COND && cmd != CMD_READ_OCR && cmd != CMD_READ_BLOCK) begin
            if (r[3]) begin
                lim = (cfg_retry == 0) ? 4'd1 : cfg_retry;
                retries = retries + 4'd1;
                drop_cs(retries < lim ? NX_RESEND : NX_PROCEED);
            end else begin
                drop_cs(NX_PROCEED);
            end
        end else begin
            evaluate();
        end
    endfunction

    function automatic void on_rx(input logic [7:0] rx);
        case (ph)
            PH_CLOCKS: begin
                bidx++;
                if (bidx < 10) put_byte(8'hFF, 1'b0);
                else issue(CMD_GO_IDLE, 0, 1'b1);
            end
            PH_CMD: begin
                bidx++;
                if (bidx < 6) begin
                    cmd_byte();
                end else begin
                    ph = PH_RESP;
                    polls = 0;
                    put_byte(8'hFF, 1'b1);
                end
            end
            PH_RESP: begin
                polls++;
                if (rx[7] && polls < RESPONSE_POLL_LIMIT) put_byte(8'hFF, 1'b1);
                else got_resp(rx);
            end
            PH_DESEL: begin
                case (nxt)
                    NX_PROCEED: evaluate();
                    NX_RESEND:  issue(cmd, arg, 1'b0);
                    NX_SDINIT:  poll_start(CMD_APP, 0);
                    NX_OCR:     issue(CMD_READ_OCR, 0, 1'b1);
                    NX_CMD1:    poll_start(CMD_SEND_OP, 32'h40000000);
                    NX_READ_OK: end_op(RC_OK);
                    default:    end_op(RC_INIT_FAIL);
                endcase
            end
            PH_ANSWER: begin
                ocr_sh = {ocr_sh[23:0], rx};
                bidx++;
                if (bidx < 4) begin
                    put_byte(8'hFF, 1'b1);
                end else if (cmd == CMD_IF_COND) begin
                    drop_cs(ocr_sh[11:8] != 4'd1 ? NX_FAIL : NX_SDINIT);
                end else if ((ocr_sh & cfg_mask) == 0) begin
                    drop_cs(NX_FAIL);
                end else begin
                    if (cfg_hce && ocr_sh[30]) hc = 1'b1;
                    poll_start(CMD_SEND_OP, 32'h40000000);
                end
            end
            PH_TOKEN: begin
                if (rx == 8'hFE) begin
                    ph = PH_DATA;
                    polls = 0;
                    put_byte(8'hFF, 1'b1);
                end else if (polls < TOKEN_POLL_LIMIT) begin
                    polls++;
                    put_byte(8'hFF, 1'b1);
                end else begin
                    end_op(RC_READ_FAIL);
                end
            end
            PH_DATA: begin
                pr.read_data = rx;
                pr.read_data_valid = 1'b1;
                polls++;
                put_byte(8'hFF, 1'b1);
                if (polls >= BLOCK_BYTES) begin
                    ph = PH_CRC;
                    bidx = 0;
                end
            end
            PH_CRC: begin
                bidx++;
                if (bidx < 2) put_byte(8'hFF, 1'b1);
                else drop_cs(NX_READ_OK);
            end
            default: ;
        endcase
    endfunction

    function automatic t_out predict(input t_in it);
        pr = '0;
        case (it.opcode)
            OP_INIT: begin
                hc = 1'b0;
                ph = PH_CLOCKS;
                bidx = 0;
                put_byte(8'hFF, 1'b0);
            end
            OP_READ: issue(CMD_READ_BLOCK, hc ? it.sector : (it.sector << BLOCK_SHIFT), 1'b1);
            OP_BYTE: if (ph != PH_IDLE) on_rx(it.rx_byte);
            default: ;
        endcase
        return pr;
    endfunction

    // ---------------- card behavior for stimulus ----------------
    function automatic logic [7:0] card_reply();
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_RESP: begin
                if (cmd == force_cmd) return force_val;
                if (r < 25) return 8'hFF;
                if (r < 30) return 8'h09;
                if (r < 33) return 8'($urandom);
                case (cmd)
                    CMD_GO_IDLE, CMD_APP: return 8'h01;
                    CMD_IF_COND: return (r < 40) ? 8'h05 : 8'h01;
                    CMD_APP_OP: return (r < 65) ? 8'h00 : 8'h01;
                    default: return 8'h00;
                endcase
            end
            PH_ANSWER: begin
                if (r < 10) return 8'($urandom);
                if (cmd == CMD_IF_COND) begin
                    case (bidx)
                        0, 1: return 8'h00;
                        2: return 8'h01;
                        default: return 8'hAA;
                    endcase
                end
                case (bidx)
                    0: return {1'b1, 1'($urandom), 6'h0};
                    1: return 8'hFF;
                    2: return 8'h80;
                    default: return 8'h00;
                endcase
            end
            PH_TOKEN: return (r < 70) ? 8'hFE : (r < 92) ? 8'hFF : 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push(input logic [1:0] op, input logic [7:0] rx, input logic [31:0] sec);
        t_in it;
        it.opcode = op;
        it.rx_byte = rx;
        it.sector = sec;
        expected_results.push_back(predict(it));
        pending_items.push_back(it);
        stim_count++;
    endtask

    task automatic feed(input int maxlen);
        for (int n = 0; n < maxlen && ph != PH_IDLE; n++)
            push(OP_BYTE, card_reply(), $urandom);
    endtask

    task automatic run_op(input logic [1:0] op, input logic [31:0] sec, input int maxlen);
        push(op, $urandom, sec);
        feed(maxlen);
    endtask

    // Card goes silent at until_ph: feed first, then 0xFF until the sequencer gives up.
    task automatic silent_card(input t_phase until_ph, input logic [7:0] first);
        while (ph != until_ph && ph != PH_IDLE) push(OP_BYTE, card_reply(), $urandom);
        if (ph != PH_IDLE) push(OP_BYTE, first, $urandom);
        while (ph != PH_IDLE) push(OP_BYTE, 8'hFF, $urandom);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RETRY: cfg_retry = val[3:0];
            REG_HCE:   cfg_hce = val[0];
            default:   cfg_mask = val;
        endcase
        @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    int  in_gap = 0;
    bit  in_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if ($urandom_range(0, 60) == 0) in_burst <= ~in_burst;
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
                in_gap <= in_burst ? 0 : $urandom_range(0, 4);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    int  out_hold = 0;
    bit  out_burst = 1'b0;

    task automatic cmp(input string name, input int e, input int a);
        if (e != a) begin
            $error("%s mismatch: expected %0h, got %0h", name, e, a);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        int   d;
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: %0h", o_data);
                failed = 1'b1;
            end else begin
                e = expected_results.pop_front();
                cmp("tx_byte", e.tx_byte, o_data.tx_byte);
                cmp("tx_valid", e.tx_valid, o_data.tx_valid);
                cmp("card_select", e.card_select, o_data.card_select);
                cmp("read_data", e.read_data, o_data.read_data);
                cmp("read_data_valid", e.read_data_valid, o_data.read_data_valid);
                cmp("done_res", e.done_res, o_data.done_res);
                cmp("result_code", e.result_code, o_data.result_code);
            end
            if ($urandom_range(0, 60) == 0) out_burst <= ~out_burst;
            d = out_burst ? 0 : $urandom_range(0, 4);
        end else begin
            d = (out_hold > 0) ? out_hold - 1 : 0;
        end
        out_hold <= d;
        i_stall <= (d != 0);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        int r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ignored items and field extremes
        push(OP_NONE, 8'hFF, 32'hFFFFFFFF);
        push(OP_BYTE, 8'h00, 32'h0);
        push(OP_BYTE, 8'hFF, 32'hFFFFFFFF);
        run_op(OP_INIT, 0, 4000);
        run_op(OP_READ, 32'hFFFFFFFF, 4000);
        run_op(OP_READ, 32'h0, 4000);
        // response timeout, then token timeout
        push(OP_READ, 8'h00, 32'h12345678);
        silent_card(PH_RESP, 8'hFF);
        push(OP_READ, 8'h00, 32'h00000001);
        silent_card(PH_TOKEN, 8'hFF);
        // start while busy aborts
        run_op(OP_INIT, 0, 7);
        run_op(OP_READ, 32'h00ABCDEF, 3);
        run_op(OP_INIT, 0, 4000);

        // zero retry limit, no high capacity, CRC error on CMD55
        reg_write(REG_RETRY, 32'd0);
        reg_write(REG_HCE, 32'd0);
        force_cmd = CMD_APP;
        force_val = 8'h09;
        run_op(OP_INIT, 0, 4000);
        force_cmd = CMD_BLOCKLEN;
        force_val = 8'h04;
        run_op(OP_INIT, 0, 4000);
        force_cmd = CMD_NO_FORCE;
        reg_write(REG_RETRY, 32'd15);
        reg_write(REG_MASK, 32'h0);
        run_op(OP_INIT, 0, 4000);
        reg_write(REG_MASK, 32'hFFFFFFFF);
        reg_write(REG_HCE, 32'd1);
        run_op(OP_INIT, 0, 4000);

        stim_count = 0;
        while (stim_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                r = $urandom_range(0, 2);
                case (r)
                    0: reg_write(REG_RETRY, $urandom_range(0, 15));
                    1: reg_write(REG_HCE, $urandom_range(0, 1));
                    default: reg_write(REG_MASK, ($urandom_range(0, 3) == 0) ? $urandom
                                                   : 32'h00FF8000);
                endcase
            end else if (r < 18) begin
                push($urandom_range(0, 1) ? OP_NONE : OP_BYTE, $urandom, $urandom);
            end else if (r < 55) begin
                run_op(OP_INIT, $urandom, 4000);
            end else if (r < 65) begin
                run_op(OP_READ, $urandom, 4000);
            end else begin
                run_op($urandom_range(0, 1) ? OP_INIT : OP_READ, $urandom,
                       $urandom_range(1, 40));
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (!failed && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/sdspi_pkg.sv
rtl/sd_spi_host_init_and_read.sv
tb/sd_spi_host_init_and_read_tb.sv
